>>> hdl/phga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phga_pkg
// Shared types, constants and the sine table of the polar hit grid accumulator.
// ----------------------------------------------------------------------------
package phga_pkg;

  localparam int MaxSideDef   = 128;
  localparam int CountBitsDef = 16;
  localparam int HalfTurn     = 180;
  localparam int FullTurn     = 2 * HalfTurn;
  localparam int QuarterTurn  = HalfTurn / 2;
  localparam int DivSteps     = 16;
  localparam int OffW         = 18;
  localparam int HitLow       = -512;
  localparam int HitHigh      = 639;

  localparam logic CfgCellSize = 1'b0;
  localparam logic CfgGridSide = 1'b1;

  localparam logic [15:0] QuarterSine [91] = '{
    16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
    16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927,
    16'd8481, 16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743,
    16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876, 16'd15384,
    16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324, 16'd18795,
    16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498, 16'd21926,
    16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
    16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842, 16'd27166,
    16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932, 16'd29197,
    16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592, 16'd30792,
    16'd30983, 16'd31164, 16'd31337, 16'd31499, 16'd31651, 16'd31795, 16'd31928,
    16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
    16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } trig_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MULT, ST_DINIT, ST_DIV, ST_ADD, ST_INDEX, ST_READ,
    ST_UPDATE, ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic mult;
    logic div_init;
    logic div_step;
    logic add;
    logic index;
    logic read;
    logic update;
    logic out_load;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic hit_in;
    logic clear_last;
    logic out_full;
  } status_t;

  // sine magnitude and sign of an angle in 0..359
  function automatic trig_t sine_lookup(input logic [8:0] d);
    trig_t r;
    logic [8:0] k;
    k = 9'd0;
    r.neg = 1'b0;
    if (d <= 9'(QuarterTurn)) begin
      k = d;
    end else if (d <= 9'(HalfTurn)) begin
      k = 9'(HalfTurn) - d;
    end else if (d <= 9'(HalfTurn + QuarterTurn)) begin
      k = d - 9'(HalfTurn);
      r.neg = 1'b1;
    end else begin
      k = 9'(FullTurn) - d;
      r.neg = 1'b1;
    end
    r.mag = QuarterSine[k[6:0]];
    return r;
  endfunction

endpackage

>>> hdl/polar_hit_grid_accumulator.sv
`timescale 1ns / 1ps
// one item at a time: a new item is taken only after the last result has
// been loaded into the output register; a pending result delays that load
// sequence: multiply, two 16-step restoring dividers sharing one loop, add,
// index, store read and update (skipped for a cell outside the grid), output
// reset: after reset a clearing pass zeroes all MAX_SIDE*MAX_SIDE entries of
// the count store, items are held off until it ends
// ----------------------------------------------------------------------------
// polar_hit_grid_accumulator
// Certainty grid update from one polar range reading.
// ----------------------------------------------------------------------------
module polar_hit_grid_accumulator #(
  parameter int MAX_SIDE   = phga_pkg::MaxSideDef,
  parameter int COUNT_BITS = phga_pkg::CountBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [6:0]         origin_x_i,
  input  logic [6:0]         origin_y_i,
  input  logic [15:0]        range_value_i,
  input  logic [8:0]         bearing_deg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               in_grid_o,
  output logic signed [10:0] hit_x_o,
  output logic signed [10:0] hit_y_o,
  output logic [15:0]        cell_count_o
);

  phga_pkg::cmd_t    cmd;
  phga_pkg::status_t status;

  phga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  phga_datapath #(
    .MAX_SIDE   (MAX_SIDE),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .range_value_i (range_value_i),
    .bearing_deg_i (bearing_deg_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .in_grid_o     (in_grid_o),
    .hit_x_o       (hit_x_o),
    .hit_y_o       (hit_y_o),
    .cell_count_o  (cell_count_o),
    .cmd_i         (cmd),
    .status_o      (status)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("block took a second item while busy");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !in_grid_o) |-> (cell_count_o == 16'd0))
    else $error("count reported for a cell outside the grid");

  a_inside_coord: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && in_grid_o) |-> (!hit_x_o[10] && !hit_y_o[10]))
    else $error("negative coordinate counted as inside");

endmodule

>>> hdl/phga_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phga_ctrl
// Sequencer: clearing pass, multiply, serial divide, grid update, output.
// ----------------------------------------------------------------------------
module phga_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  phga_pkg::status_t  status_i,
  output phga_pkg::cmd_t     cmd_o
);

  phga_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= phga_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      phga_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) state_d = phga_pkg::ST_IDLE;
      end
      phga_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = phga_pkg::ST_MULT;
        end
      end
      phga_pkg::ST_MULT: begin
        cmd_o.mult = 1'b1;
        state_d    = phga_pkg::ST_DINIT;
      end
      phga_pkg::ST_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = phga_pkg::ST_DIV;
      end
      phga_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) state_d = phga_pkg::ST_ADD;
      end
      phga_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = phga_pkg::ST_INDEX;
      end
      phga_pkg::ST_INDEX: begin
        // outside cells skip the store
        cmd_o.index = 1'b1;
        state_d     = status_i.hit_in ? phga_pkg::ST_READ : phga_pkg::ST_DONE;
      end
      phga_pkg::ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = phga_pkg::ST_UPDATE;
      end
      phga_pkg::ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = phga_pkg::ST_DONE;
      end
      phga_pkg::ST_DONE: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = phga_pkg::ST_IDLE;
        end
      end
      default: state_d = phga_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != phga_pkg::ST_IDLE);

endmodule

>>> hdl/phga_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phga_datapath
// Config registers, trig multiply, two serial dividers and the count store.
// ----------------------------------------------------------------------------
module phga_datapath #(
  parameter int MAX_SIDE   = phga_pkg::MaxSideDef,
  parameter int COUNT_BITS = phga_pkg::CountBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_index_i,
  input  logic [11:0]          cfg_data_i,
  input  logic [6:0]           origin_x_i,
  input  logic [6:0]           origin_y_i,
  input  logic [15:0]          range_value_i,
  input  logic [8:0]           bearing_deg_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 in_grid_o,
  output logic signed [10:0]   hit_x_o,
  output logic signed [10:0]   hit_y_o,
  output logic [15:0]          cell_count_o,
  input  phga_pkg::cmd_t       cmd_i,
  output phga_pkg::status_t    status_o
);

  localparam int SideW  = $clog2(MAX_SIDE + 1);
  localparam int XW     = $clog2(MAX_SIDE);
  localparam int Depth  = MAX_SIDE * MAX_SIDE;
  localparam int AW     = $clog2(Depth);
  localparam int OffW   = phga_pkg::OffW;
  localparam int StepW  = $clog2(phga_pkg::DivSteps);
  localparam logic [COUNT_BITS-1:0] CountMax = '1;

  logic [11:0] cell_q;
  logic [7:0]  grid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= 12'd1;
      grid_q <= 8'd127;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        phga_pkg::CfgCellSize: cell_q <= cfg_data_i;
        phga_pkg::CfgGridSide: grid_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  logic [SideW-1:0] side_w;
  assign side_w = ({24'd0, grid_q} > 32'(MAX_SIDE)) ? SideW'(MAX_SIDE) : SideW'(grid_q);

  // input capture and angle reduction
  logic [6:0]  ox_q, oy_q;
  logic [15:0] range_q;
  logic [8:0]  bear_q;
  logic [8:0]  bear_w, cang_w;
  logic [9:0]  csum_w;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q    <= origin_x_i;
      oy_q    <= origin_y_i;
      range_q <= range_value_i;
      bear_q  <= (bearing_deg_i >= 9'(phga_pkg::FullTurn)) ?
                 bearing_deg_i - 9'(phga_pkg::FullTurn) : bearing_deg_i;
    end
  end

  assign bear_w = bear_q;
  assign csum_w = {1'b0, bear_w} + 10'(phga_pkg::QuarterTurn);
  assign cang_w = (csum_w >= 10'(phga_pkg::FullTurn)) ?
                  9'(csum_w - 10'(phga_pkg::FullTurn)) : csum_w[8:0];

  phga_pkg::trig_t cos_w, sin_w;
  assign cos_w = phga_pkg::sine_lookup(cang_w);
  assign sin_w = phga_pkg::sine_lookup(bear_w);

  logic [31:0] px_q, py_q;
  logic        nx_q, ny_q;
  logic [11:0] cs_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mult) begin
      px_q <= range_q * cos_w.mag;
      py_q <= range_q * sin_w.mag;
      nx_q <= cos_w.neg;
      ny_q <= sin_w.neg;
      cs_q <= (cell_q == 12'd0) ? 12'd1 : cell_q;
    end
  end

  // a negative offset needs the ceiling, so round the scaled product up
  logic [32:0] ux_w, uy_w;
  assign ux_w = nx_q ? {1'b0, px_q} + 33'd32767 : {1'b0, px_q};
  assign uy_w = ny_q ? {1'b0, py_q} + 33'd32767 : {1'b0, py_q};

  logic [15:0]      dx_q, dy_q;
  logic [11:0]      rx_q, ry_q;
  logic [StepW-1:0] step_q;
  logic [12:0]      sx_w, sy_w;
  logic             bx_w, by_w;

  assign sx_w = {rx_q, dx_q[15]};
  assign sy_w = {ry_q, dy_q[15]};
  assign bx_w = (sx_w >= {1'b0, cs_q});
  assign by_w = (sy_w >= {1'b0, cs_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dx_q   <= ux_w[30:15];
      dy_q   <= uy_w[30:15];
      rx_q   <= '0;
      ry_q   <= '0;
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      rx_q   <= bx_w ? 12'(sx_w - {1'b0, cs_q}) : sx_w[11:0];
      ry_q   <= by_w ? 12'(sy_w - {1'b0, cs_q}) : sy_w[11:0];
      dx_q   <= {dx_q[14:0], bx_w};
      dy_q   <= {dy_q[14:0], by_w};
      step_q <= step_q + StepW'(1);
    end
  end

  assign status_o.div_last = (step_q == StepW'(phga_pkg::DivSteps - 1));

  logic signed [OffW-1:0] offx_w, offy_w, hx_w, hy_w;
  assign offx_w = nx_q ? -$signed(OffW'(dx_q) + OffW'(rx_q != 12'd0)) : $signed(OffW'(dx_q));
  assign offy_w = ny_q ? -$signed(OffW'(dy_q) + OffW'(ry_q != 12'd0)) : $signed(OffW'(dy_q));
  assign hx_w   = offx_w + $signed(OffW'(ox_q));
  assign hy_w   = offy_w + $signed(OffW'(oy_q));

  logic signed [OffW-1:0] hx_q, hy_q;
  logic                   inside_q;
  logic signed [OffW-1:0] side_s;
  assign side_s = $signed(OffW'(side_w));

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      hx_q     <= hx_w;
      hy_q     <= hy_w;
      inside_q <= (hx_w >= 0) && (hy_w >= 0) && (hx_w < side_s) && (hy_w < side_s);
    end
  end
  assign status_o.hit_in = inside_q;

  logic [AW-1:0]            addr_q;
  logic [XW+SideW:0]        prod_w;
  assign prod_w = (XW+SideW+1)'(hx_q[XW-1:0]) * (XW+SideW+1)'(side_w)
                + (XW+SideW+1)'(hy_q[XW-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.index) addr_q <= prod_w[AW-1:0];
  end

  // count store with clearing pass after reset
  logic [COUNT_BITS-1:0] mem_q [Depth];
  logic [COUNT_BITS-1:0] rd_q, cnew_w, count_q;
  logic [AW-1:0]         clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + AW'(1);
    end
  end
  assign status_o.clear_last = (clr_q == AW'(Depth - 1));

  assign cnew_w = (rd_q == CountMax) ? rd_q : rd_q + COUNT_BITS'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      mem_q[clr_q] <= '0;
    end else if (cmd_i.update) begin
      mem_q[addr_q] <= cnew_w;
    end
    if (cmd_i.read) rd_q <= mem_q[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.index) begin
      count_q <= '0;
    end else if (cmd_i.update) begin
      count_q <= cnew_w;
    end
  end

  // output register
  logic                   out_valid_q;
  logic                   in_grid_q;
  logic signed [10:0]     hit_x_q, hit_y_q;
  logic [15:0]            cell_count_q;
  logic [31:0]            c32_w;

  function automatic logic [10:0] sat_coord(input logic signed [OffW-1:0] v);
    logic [10:0] r;
    r = v[10:0];
    if (v < $signed(OffW'(phga_pkg::HitLow))) r = 11'(phga_pkg::HitLow);
    if (v > $signed(OffW'(phga_pkg::HitHigh))) r = 11'(phga_pkg::HitHigh);
    return r;
  endfunction

  assign c32_w = 32'(count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      in_grid_q    <= inside_q;
      hit_x_q      <= $signed(sat_coord(hx_q));
      hit_y_q      <= $signed(sat_coord(hy_q));
      cell_count_q <= c32_w[15:0];
    end
  end

  assign status_o.out_full = out_valid_q && out_stall_i;
  assign out_valid_o  = out_valid_q;
  assign in_grid_o    = in_grid_q;
  assign hit_x_o      = hit_x_q;
  assign hit_y_o      = hit_y_q;
  assign cell_count_o = cell_count_q;

endmodule
